>>> hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared definitions for the block bitmap allocator
// Map geometry, command codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BLOCK_COUNT = 8192;
  localparam int MAP_BYTES   = (BLOCK_COUNT + 7) / 8;
  localparam int BYTE_AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int LIM_W       = BYTE_AW + 4;

  localparam int IDX_W       = 13;
  localparam int RSV_W       = 14;
  localparam logic [RSV_W-1:0] RSV_RESET = RSV_W'(4);

  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam int         TAIL_BITS = BLOCK_COUNT % 8;
  // bits of the last byte that lie beyond the map
  localparam logic [7:0] TAIL_MASK = (TAIL_BITS == 0) ? 8'h00 : 8'(8'hFF << TAIL_BITS);
  localparam logic [BYTE_AW-1:0] LAST_BYTE = BYTE_AW'(MAP_BYTES - 1);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MARK    = 2'd2,
    CMD_FORMAT  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic [2:0] pos;
    logic [7:0] set_byte;
    logic [7:0] fmt_byte;
  } unit_res_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] granted;
    logic             was;
  } res_t;

endpackage

>>> hw/rtl/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator: first-fit block bitmap allocator
// Used/free bitmap over the disk blocks with allocate, release, mark-used
// and format commands.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: command, tdata: block_index
//  out_    | out | out_tvalid/tready  | tuser: status, tdata: granted, was_used
//  cfg_    | in  | cfg_we             | cfg_data: reserved_blocks
//
//  allocate: one map byte checked per cycle by the byte unit, behind a
//    memory with a registered read port and a separate write port
//  format: one byte written per cycle
//  release / mark used: read, modify-write, result
//  after reset a clearing sweep over the whole map runs before in_tready rises
//  a result waits in the output register; the next transaction is taken
//  meanwhile and holds in its last step until the output register frees up
// ----------------------------------------------------------------------------
module block_bitmap_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,   // [12:0] block_index, [15:13] zero
  input  logic [1:0]                in_tuser,   // [1:0] command
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // [12:0] granted_index, [13] was_used
  output logic                      out_tuser,  // [0] status
  input  logic                      cfg_we,
  input  logic [bba_pkg::RSV_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RMW_RD = 7'b0000100,
    S_RMW_WR = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_FMT    = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [bba_pkg::RSV_W-1:0]      rsv_r;
  logic [bba_pkg::BYTE_AW-1:0]    ptr_r, ptr_nxt;
  logic [bba_pkg::BYTE_AW-1:0]    chk_addr_r, chk_addr_nxt;
  logic                           chk_valid_r, chk_valid_nxt;
  logic [bba_pkg::LIM_W-1:0]      lim_r, lim_nxt;
  bba_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [bba_pkg::BYTE_AW-1:0]    baddr_r, baddr_nxt;
  logic [2:0]                     bit_r, bit_nxt;
  bba_pkg::res_t                  res_r, res_nxt;
  logic                           out_valid_r;
  bba_pkg::res_t                  out_res_r;

  logic [7:0]                     mem [bba_pkg::MAP_BYTES];
  logic [7:0]                     rd_data_r;
  logic [bba_pkg::BYTE_AW-1:0]    rd_addr;
  logic                           wr_en;
  logic [bba_pkg::BYTE_AW-1:0]    wr_addr;
  logic [7:0]                     wr_data;

  logic [bba_pkg::BYTE_AW-1:0]    unit_addr;
  bba_pkg::unit_res_t             unit_res;
  logic                           in_fire;
  logic                           out_free;
  logic [bba_pkg::IDX_W-1:0]      in_idx;
  logic [7:0]                     bit_mask;

  assign in_idx    = in_tdata[bba_pkg::IDX_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign bit_mask  = 8'(8'd1 << bit_r);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {2'b00, out_res_r.was, out_res_r.granted};

  assign unit_addr = (state_r == S_SCAN) ? chk_addr_r : ptr_r;

  bba_byte_unit u_unit (
    .byte_addr (unit_addr),
    .byte_in   (rd_data_r),
    .lim       (lim_r),
    .res       (unit_res)
  );

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    chk_addr_nxt  = chk_addr_r;
    chk_valid_nxt = chk_valid_r;
    lim_nxt       = lim_r;
    cmd_nxt       = cmd_r;
    baddr_nxt     = baddr_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    rd_addr       = baddr_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = unit_res.fmt_byte;

    case (state_r)
      S_CLEAR, S_FMT: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == bba_pkg::LAST_BYTE) begin
          state_nxt = (state_r == S_FMT) ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = bba_pkg::cmd_t'(in_tuser);
          baddr_nxt     = bba_pkg::BYTE_AW'(in_idx >> 3);
          bit_nxt       = in_idx[2:0];
          ptr_nxt       = '0;
          chk_valid_nxt = 1'b0;
          res_nxt       = '0;
          case (bba_pkg::cmd_t'(in_tuser))
            bba_pkg::CMD_ALLOC: begin
              state_nxt = S_SCAN;
            end
            bba_pkg::CMD_RELEASE, bba_pkg::CMD_MARK: begin
              // blocks past the map change nothing
              state_nxt = (32'(in_idx) < bba_pkg::BLOCK_COUNT) ? S_RMW_RD : S_FIN;
            end
            bba_pkg::CMD_FORMAT: begin
              lim_nxt   = (32'(rsv_r) > bba_pkg::BLOCK_COUNT) ?
                          bba_pkg::LIM_W'(bba_pkg::BLOCK_COUNT) : bba_pkg::LIM_W'(rsv_r);
              state_nxt = S_FMT;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_RMW_RD: begin
        state_nxt = S_RMW_WR;
      end
      S_RMW_WR: begin
        wr_en       = 1'b1;
        wr_addr     = baddr_r;
        wr_data     = (cmd_r == bba_pkg::CMD_MARK) ? (rd_data_r | bit_mask)
                                                   : (rd_data_r & ~bit_mask);
        res_nxt.was = rd_data_r[bit_r];
        state_nxt   = S_FIN;
      end
      S_SCAN: begin
        // read issued at ptr_r, data of chk_addr_r checked this cycle
        rd_addr = ptr_r;
        if (chk_valid_r && !unit_res.full) begin
          wr_en           = 1'b1;
          wr_addr         = chk_addr_r;
          wr_data         = unit_res.set_byte;
          res_nxt.granted = bba_pkg::IDX_W'({chk_addr_r, unit_res.pos});
          state_nxt       = S_FIN;
        end else if (chk_valid_r && chk_addr_r == bba_pkg::LAST_BYTE) begin
          res_nxt.status = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          chk_addr_nxt  = ptr_r;
          chk_valid_nxt = 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      chk_valid_r <= 1'b0;
      lim_r       <= '0;
      rsv_r       <= bba_pkg::RSV_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      chk_valid_r <= chk_valid_nxt;
      lim_r       <= lim_nxt;
      if (cfg_we) begin
        rsv_r <= cfg_data;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    cmd_r      <= cmd_nxt;
    baddr_r    <= baddr_nxt;
    bit_r      <= bit_nxt;
    res_r      <= res_nxt;
    if (state_r == S_FIN && out_free) begin
      out_res_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("map written while idle");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status) |-> (out_res_r.granted == '0 && !out_res_r.was))
    else $error("full result carries nonzero fields");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && chk_valid_r && chk_addr_r == bba_pkg::LAST_BYTE)
      |=> (state_r == S_FIN))
    else $error("scan ran past the last map byte");

  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished transaction did not reach the output register");
`endif

endmodule

>>> hw/rtl/bba_byte_unit.sv
// ----------------------------------------------------------------------------
// bba_byte_unit: bitmap byte unit
// Finds the lowest free bit of one map byte and builds the byte a format
// writes at a given address.
// ----------------------------------------------------------------------------
module bba_byte_unit (
  input  logic [bba_pkg::BYTE_AW-1:0] byte_addr,
  input  logic [7:0]                  byte_in,
  input  logic [bba_pkg::LIM_W-1:0]   lim,
  output bba_pkg::unit_res_t          res
);

  logic [7:0]                eff;
  logic [7:0]                lowz;
  logic [2:0]                pos;
  logic [bba_pkg::LIM_W-1:0] base;
  logic [bba_pkg::LIM_W-1:0] diff;

  always_comb begin
    // bits past the end of the map count as used
    eff = byte_in;
    if (byte_addr == bba_pkg::LAST_BYTE) begin
      eff = byte_in | bba_pkg::TAIL_MASK;
    end
    lowz = ~eff & (eff + 8'd1);
    pos  = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (lowz[b]) begin
        pos = 3'(b);
      end
    end
    res.full     = (eff == bba_pkg::FULL_BYTE);
    res.pos      = pos;
    res.set_byte = byte_in | lowz;

    base = {1'b0, byte_addr, 3'b000};
    diff = lim - base;
    if (lim >= base + bba_pkg::LIM_W'(8)) begin
      res.fmt_byte = bba_pkg::FULL_BYTE;
    end else if (lim > base) begin
      res.fmt_byte = ~(bba_pkg::FULL_BYTE << diff[2:0]);
    end else begin
      res.fmt_byte = 8'h00;
    end
  end

endmodule

>>> test/block_bitmap_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_test: self-checking bench for the bitmap allocator
// Drives allocate, release, mark-used and format commands over the input
// stream and keeps a shadow copy of the used/free map. Every result is
// checked against it. The reserved count is changed between phases, and
// both stream sides stall at random and during one long receiver hold-off.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_test;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [15:0]                in_tdata = '0;   // [12:0] block_index, [15:13] zero
  logic [1:0]                 in_tuser = '0;   // [1:0] command
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [15:0]                out_tdata;       // [12:0] granted_index, [13] was_used
  logic                       out_tuser;       // [0] status
  logic                       cfg_we = 1'b0;
  logic [bba_pkg::RSV_W-1:0]  cfg_data = '0;

  // shadow map and register
  logic [7:0]                 used_map [bba_pkg::MAP_BYTES];
  logic [bba_pkg::RSV_W-1:0]  reserve_count = bba_pkg::RSV_RESET;

  bba_pkg::res_t              pending_results [$];
  bit                         idle_on = 1'b1;
  int                         receiver_hold = 0;
  int                         error_count = 0;
  int                         commands_sent = 0;
  int                         results_checked = 0;
  int                         grants_seen = 0;
  int                         full_seen = 0;

  block_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic bba_pkg::res_t predict_command(
    bba_pkg::cmd_t cmd, logic [bba_pkg::IDX_W-1:0] idx);
    bba_pkg::res_t r;
    bit            found;
    int            lim;
    r = '0;
    found = 1'b0;
    case (cmd)
      bba_pkg::CMD_ALLOC: begin
        for (int n = 0; n < bba_pkg::MAP_BYTES && !found; n++) begin
          if (used_map[n] != bba_pkg::FULL_BYTE) begin
            for (int b = 0; b < 8 && !found; b++) begin
              if (!used_map[n][b]) begin
                found = 1'b1;
                // a zero bit past the end of the map does not count
                if (n * 8 + b < bba_pkg::BLOCK_COUNT) begin
                  used_map[n][b] = 1'b1;
                  r.granted = bba_pkg::IDX_W'(n * 8 + b);
                end else begin
                  r.status = 1'b1;
                end
              end
            end
          end
        end
        if (!found) r.status = 1'b1;
        if (r.status) full_seen++;
        else grants_seen++;
      end
      bba_pkg::CMD_RELEASE, bba_pkg::CMD_MARK: begin
        if (int'(idx) < bba_pkg::BLOCK_COUNT) begin
          r.was = used_map[idx >> 3][idx[2:0]];
          used_map[idx >> 3][idx[2:0]] = (cmd == bba_pkg::CMD_MARK);
        end
      end
      default: begin
        lim = (int'(reserve_count) > bba_pkg::BLOCK_COUNT) ? bba_pkg::BLOCK_COUNT
                                                           : int'(reserve_count);
        for (int n = 0; n < bba_pkg::MAP_BYTES; n++) used_map[n] = '0;
        for (int i = 0; i < lim; i++) used_map[i >> 3][i % 8] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // result checker and receiver stall control
  always @(posedge clk) begin
    bba_pkg::res_t want;
    if (out_tvalid && out_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result with no command outstanding: status %0d granted %0d was %0d",
               out_tuser, out_tdata[12:0], out_tdata[13]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          error_count++;
        end
        if (out_tdata[12:0] !== want.granted) begin
          $error("granted_index: expected %0d, got %0d", want.granted, out_tdata[12:0]);
          error_count++;
        end
        if (out_tdata[13] !== want.was) begin
          $error("was_used: expected %0d, got %0d", want.was, out_tdata[13]);
          error_count++;
        end
      end
    end
    if (receiver_hold > 0) begin
      out_tready <= 1'b0;
      receiver_hold--;
    end else begin
      out_tready <= !(idle_on && $urandom_range(0, 99) < 25);
    end
  end

  task automatic send_item(input bba_pkg::cmd_t cmd, input logic [bba_pkg::IDX_W-1:0] idx);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= 16'(idx);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_command(cmd, idx));
    commands_sent++;
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    end_burst();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reserved_count(input int unsigned count);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= bba_pkg::RSV_W'(count);
    @(posedge clk);
    cfg_we   <= 1'b0;
    reserve_count = bba_pkg::RSV_W'(count);
    @(posedge clk);
  endtask

  task automatic send_random_item();
    int                         pick;
    bba_pkg::cmd_t              cmd;
    logic [bba_pkg::IDX_W-1:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 40) cmd = bba_pkg::CMD_ALLOC;
    else if (pick < 68) cmd = bba_pkg::CMD_RELEASE;
    else if (pick < 95) cmd = bba_pkg::CMD_MARK;
    else cmd = bba_pkg::CMD_FORMAT;
    // half the indexes land in the low region where allocation happens
    if ($urandom_range(0, 1)) idx = bba_pkg::IDX_W'($urandom_range(0, 8 * 64 - 1));
    else idx = bba_pkg::IDX_W'($urandom);
    send_item(cmd, idx);
  endtask

  task automatic test_reset_defaults();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // clearing sweep runs first
    while (!in_tready) @(posedge clk);
    send_item(bba_pkg::CMD_ALLOC, '0);
    send_item(bba_pkg::CMD_FORMAT, bba_pkg::IDX_W'(8191));
    send_item(bba_pkg::CMD_ALLOC, '0);
    wait_idle();
  endtask

  task automatic test_release_mark();
    send_item(bba_pkg::CMD_RELEASE, bba_pkg::IDX_W'(4));
    send_item(bba_pkg::CMD_RELEASE, bba_pkg::IDX_W'(4));
    send_item(bba_pkg::CMD_MARK, bba_pkg::IDX_W'(8191));
    send_item(bba_pkg::CMD_MARK, bba_pkg::IDX_W'(8191));
    send_item(bba_pkg::CMD_RELEASE, bba_pkg::IDX_W'(0));
    send_item(bba_pkg::CMD_ALLOC, '0);
    send_item(bba_pkg::CMD_MARK, bba_pkg::IDX_W'(13'h1555));
    send_item(bba_pkg::CMD_MARK, bba_pkg::IDX_W'(13'h0AAA));
    send_item(bba_pkg::CMD_ALLOC, '0);
    wait_idle();
  endtask

  task automatic test_full_map();
    write_reserved_count(bba_pkg::BLOCK_COUNT);
    send_item(bba_pkg::CMD_FORMAT, '0);
    send_item(bba_pkg::CMD_ALLOC, '0);
    send_item(bba_pkg::CMD_RELEASE, bba_pkg::IDX_W'(8191));
    send_item(bba_pkg::CMD_ALLOC, '0);
    send_item(bba_pkg::CMD_ALLOC, '0);
    send_item(bba_pkg::CMD_RELEASE, bba_pkg::IDX_W'(4000));
    send_item(bba_pkg::CMD_ALLOC, '0);
    wait_idle();
  endtask

  task automatic test_reserved_extremes();
    // count above the map size saturates
    write_reserved_count(16383);
    send_item(bba_pkg::CMD_FORMAT, '0);
    send_item(bba_pkg::CMD_ALLOC, '0);
    write_reserved_count(0);
    send_item(bba_pkg::CMD_FORMAT, '0);
    send_item(bba_pkg::CMD_ALLOC, '0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    receiver_hold = 600;
    for (int i = 0; i < 12; i++) begin
      send_item(($urandom_range(0, 1) != 0) ? bba_pkg::CMD_MARK : bba_pkg::CMD_RELEASE,
                bba_pkg::IDX_W'($urandom_range(0, 63)));
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned settings [5] = '{9, 0, 4000, 8192, 100};
    int          counts [5]   = '{120, 100, 90, 20, 170};
    for (int p = 0; p < 5; p++) begin
      write_reserved_count(settings[p]);
      // one phase without any stalls on either side
      idle_on = (p != 1);
      send_item(bba_pkg::CMD_FORMAT, '0);
      for (int i = 1; i < counts[p]; i++) send_random_item();
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int n = 0; n < bba_pkg::MAP_BYTES; n++) used_map[n] = '0;
    test_reset_defaults();
    test_release_mark();
    test_full_map();
    test_reserved_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (bba_pkg::MAP_BYTES + 8) @(posedge clk);
    $display("sent %0d commands over several reserved-count settings, %0d results checked",
             commands_sent, results_checked);
    $display("allocations: %0d granted, %0d found the map full", grants_seen, full_seen);
    if (error_count == 0) begin
      $display("block_bitmap_allocator: match");
    end else begin
      $display("block_bitmap_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("block_bitmap_allocator: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_byte_unit.sv
hw/rtl/block_bitmap_allocator.sv
test/block_bitmap_allocator_test.sv
